>>> rtl/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the block bitmap allocator
// Holds the item structs, status and finish codes, and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int INDEX_W        = 10;
  localparam int COUNT_W        = 11;
  localparam int STATUS_W       = 2;
  localparam int BITS_PER_BYTE  = 8;
  localparam int BYTES_PER_WORD = 8;
  localparam int WORD_W         = BITS_PER_BYTE * BYTES_PER_WORD;
  localparam int BYTE_SEL_W     = $clog2(BYTES_PER_WORD);
  localparam int BIT_SEL_W      = $clog2(BITS_PER_BYTE);
  localparam int WORD_SHIFT     = BYTE_SEL_W + BIT_SEL_W;

  localparam logic [7:0]         BYTE_FULL   = 8'hFF;
  localparam logic [COUNT_W-1:0] TOTAL_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VOLUME_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INCONSISTENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE     = 2'd3;

  // Finish codes: how the controller closes a request
  localparam logic [2:0] FIN_NONE  = 3'd0;
  localparam logic [2:0] FIN_VOL   = 3'd1;
  localparam logic [2:0] FIN_ALLOC = 3'd2;
  localparam logic [2:0] FIN_INCON = 3'd3;
  localparam logic [2:0] FIN_FREE  = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] block_index;
  } bba_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  allocated_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  allocated_count;
  } bba_out_t;

  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       scan_step;
    logic [2:0] fin;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic vol_full;
    logic scan_hit;
    logic scan_last;
  } bba_stat_t;

endpackage
`default_nettype wire

>>> rtl/bba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl: request sequencer of the block bitmap allocator
// Runs the clearing sweep after reset, takes requests and steps the bitmap
// scan or the free check, then closes each request with a finish code.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               operation,
  input  wire bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t       cmd,
  output logic                    busy
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FREE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.fin   = bba_pkg::FIN_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = (operation == bba_pkg::OP_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.vol_full) begin
          cmd.fin   = bba_pkg::FIN_VOL;
          state_nxt = S_IDLE;
        end else if (stat.scan_hit) begin
          cmd.fin   = bba_pkg::FIN_ALLOC;
          state_nxt = S_IDLE;
        end else if (stat.scan_last) begin
          cmd.fin   = bba_pkg::FIN_INCON;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.fin   = bba_pkg::FIN_FREE;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/bba_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_dp: datapath of the block bitmap allocator
// Bitmap memory of 64-bit words, read pipeline, first-zero search, used
// count, total register and the registered result.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int BITMAP_BYTES = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bba_pkg::bba_cmd_t              cmd,
  input  wire bba_pkg::bba_in_t               in_item,
  input  wire logic                           cfg_we,
  input  wire logic [bba_pkg::COUNT_W-1:0]    cfg_wdata,
  output bba_pkg::bba_stat_t                  stat,
  output logic                                out_valid,
  output bba_pkg::bba_out_t                   out_item
);

  localparam int WORDS  = (BITMAP_BYTES + bba_pkg::BYTES_PER_WORD - 1) /
                          bba_pkg::BYTES_PER_WORD;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BLOCKS = BITMAP_BYTES * bba_pkg::BITS_PER_BYTE;
  localparam int WW     = bba_pkg::WORD_W;
  localparam int OW     = bba_pkg::WORD_SHIFT;

  logic [WW-1:0] mem [WORDS];

  logic [AW-1:0]               addr_r;
  logic [AW-1:0]               addr_nxt;
  logic [AW-1:0]               chk_addr_r;
  logic [WW-1:0]               rdata_r;
  logic [OW-1:0]               off_r;
  logic                        inrange_r;
  logic [bba_pkg::COUNT_W-1:0] count_r;
  logic [bba_pkg::COUNT_W-1:0] count_nxt;
  logic [bba_pkg::COUNT_W-1:0] total_r;
  logic                        out_valid_r;
  bba_pkg::bba_out_t           out_item_r;
  bba_pkg::bba_out_t           out_item_nxt;

  logic          in_range;
  logic [AW-1:0] acc_addr;
  logic          re;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  logic [WW-1:0] wd;

  logic [bba_pkg::BYTES_PER_WORD-1:0] byte_open;
  logic [bba_pkg::BYTE_SEL_W-1:0]     sel_byte;
  logic [bba_pkg::BIT_SEL_W-1:0]      sel_bit;
  logic [7:0]                         byte_val;
  logic                               byte_found;
  logic                               bit_found;
  logic [OW-1:0]                      alloc_off;
  logic                               free_ok;

  // Decode the request word address; out-of-range frees read word zero
  always_comb begin
    in_range = (32'(in_item.block_index) < BLOCKS);
    acc_addr = '0;
    if (in_item.operation == bba_pkg::OP_FREE && in_range) begin
      acc_addr = AW'(32'(in_item.block_index) >> OW);
    end
  end

  // Search the checked word: first open byte, then its lowest zero bit
  always_comb begin
    byte_found = 1'b0;
    sel_byte   = '0;
    for (int j = 0; j < bba_pkg::BYTES_PER_WORD; j++) begin
      byte_open[j] = (rdata_r[j*8 +: 8] != bba_pkg::BYTE_FULL) &&
                     ((32'(chk_addr_r) * bba_pkg::BYTES_PER_WORD + j) < BITMAP_BYTES);
      if (byte_open[j] && !byte_found) begin
        byte_found = 1'b1;
        sel_byte   = bba_pkg::BYTE_SEL_W'(j);
      end
    end
    byte_val  = rdata_r[sel_byte*8 +: 8];
    bit_found = 1'b0;
    sel_bit   = '0;
    for (int b = 0; b < bba_pkg::BITS_PER_BYTE; b++) begin
      if (!byte_val[b] && !bit_found) begin
        bit_found = 1'b1;
        sel_bit   = bba_pkg::BIT_SEL_W'(b);
      end
    end
    alloc_off = {sel_byte, sel_bit};
  end

  assign free_ok = inrange_r && rdata_r[off_r];

  always_comb begin
    stat.clr_last  = (addr_r == AW'(WORDS - 1));
    stat.vol_full  = (count_r >= total_r);
    stat.scan_hit  = |byte_open;
    stat.scan_last = (chk_addr_r == AW'(WORDS - 1));
  end

  // Memory port control
  always_comb begin
    re = cmd.accept | cmd.scan_step;
    ra = cmd.accept ? acc_addr : addr_r;
    we = cmd.clear || (cmd.fin == bba_pkg::FIN_ALLOC) ||
         ((cmd.fin == bba_pkg::FIN_FREE) && free_ok);
    wa = cmd.clear ? addr_r : chk_addr_r;
    if (cmd.clear) begin
      wd = '0;
    end else if (cmd.fin == bba_pkg::FIN_ALLOC) begin
      wd = rdata_r | (WW'(1) << alloc_off);
    end else begin
      wd = rdata_r & ~(WW'(1) << off_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  // Address counter: clear sweep and scan both advance it; an accept loads word one
  always_comb begin
    addr_nxt = addr_r;
    if (cmd.clear || cmd.scan_step) begin
      addr_nxt = addr_r + AW'(1);
    end else if (cmd.accept) begin
      addr_nxt = AW'(1);
    end
  end

  // Result and count update
  always_comb begin
    count_nxt    = count_r;
    out_item_nxt = out_item_r;
    out_item_nxt.allocated_index = '0;
    unique case (cmd.fin)
      bba_pkg::FIN_VOL: begin
        out_item_nxt.status = bba_pkg::ST_VOLUME_FULL;
      end
      bba_pkg::FIN_ALLOC: begin
        count_nxt = count_r + bba_pkg::COUNT_W'(1);
        out_item_nxt.status = bba_pkg::ST_OK;
        out_item_nxt.allocated_index = bba_pkg::INDEX_W'({chk_addr_r, alloc_off});
      end
      bba_pkg::FIN_INCON: begin
        out_item_nxt.status = bba_pkg::ST_INCONSISTENT;
      end
      bba_pkg::FIN_FREE: begin
        if (free_ok) begin
          out_item_nxt.status = bba_pkg::ST_OK;
          if (count_r != '0) begin
            count_nxt = count_r - bba_pkg::COUNT_W'(1);
          end
        end else begin
          out_item_nxt.status = bba_pkg::ST_BAD_FREE;
        end
      end
      default: begin
        out_item_nxt = out_item_r;
      end
    endcase
    out_item_nxt.allocated_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      count_r     <= '0;
      total_r     <= bba_pkg::TOTAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      addr_r      <= addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (cmd.fin != bba_pkg::FIN_NONE);
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      chk_addr_r <= ra;
    end
    if (cmd.accept) begin
      off_r     <= in_item.block_index[OW-1:0];
      inrange_r <= in_range;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> rtl/block_bitmap_allocator_unit.sv
`default_nettype none
// Sequence: a free reads the word of its block and then updates it; an allocate
//   scans bitmap words (8 bytes per word) from word zero to the first with a free
//   block, and a refused or failed allocate ends at the volume check or last word.
// Throughput: one item at a time; start is taken again in the cycle that shows
//   the result. The scan reads one bitmap word per cycle from a single port.
// Reset: rst_n clears state, then a sweep over every bitmap word zeroes
//   the bitmap with busy high. Results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit: first-fit free-block bitmap allocator
// Allocates the lowest free block subject to a configured block total and
// frees single blocks, keeping a count of allocated blocks.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit #(
  parameter int BITMAP_BYTES = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bba_pkg::bba_in_t            in_item,
  output logic                             out_valid,
  output bba_pkg::bba_out_t                out_item,
  input  wire logic                        cfg_we,
  input  wire logic [bba_pkg::COUNT_W-1:0] cfg_wdata
);

  // Controller to datapath bundles
  bba_pkg::bba_cmd_t  cmd;
  bba_pkg::bba_stat_t stat;

  // Sequence the clear sweep, the scan and the free check
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_item.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the bitmap, the used count, the block total and the result register
  bba_dp #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // An accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result only follows a cycle of work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // Each strobe lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Only a successful allocate hands out a nonzero index
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != bba_pkg::ST_OK) |-> (out_item.allocated_index == '0))
    else $error("nonzero index on a failed request");
`endif

endmodule
`default_nettype wire
